>>> hdl/svf_pkg.sv
// shared types, codes and saturation helpers for the two-pass state-variable filter
// no dependencies; compiled first
package svf_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 24;

  localparam logic [CfgIdxW-1:0] REG_BYPASS = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_MODE   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_DAMP   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_GAIN   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_RATE   = 3'd4;

  localparam logic [23:0] RATE_RESET = 24'd194783;
  localparam logic [16:0] F_MAX = 17'h1FFFF;

  localparam logic [2:0] MODE_LOW   = 3'd0;
  localparam logic [2:0] MODE_HIGH  = 3'd1;
  localparam logic [2:0] MODE_BAND  = 3'd2;
  localparam logic [2:0] MODE_NOTCH = 3'd3;
  localparam logic [2:0] MODE_LMH   = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_F,
    ST_G,
    ST_LB,
    ST_DB,
    ST_HI,
    ST_FH,
    ST_BD,
    ST_ACC,
    ST_DONE
  } svf_state_t;

  // operand pair for the shared multiplier
  typedef enum logic [2:0] {
    MUL_CR,  // cutoff * rate factor
    MUL_GX,  // input gain * sample
    MUL_FB,  // f * band
    MUL_DB,  // damping * band
    MUL_FH   // f * high
  } mul_op_t;

  typedef struct packed {
    mul_op_t mul_op;
    logic    clr_acc;
    logic    upd_f;
    logic    upd_gx;
    logic    upd_low;
    logic    upd_high;
    logic    upd_band;
    logic    upd_acc;
    logic    finish;
  } svf_ctrl_t;

  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    logic signed [35:0] hi_lim;
    logic signed [35:0] lo_lim;
    hi_lim = 36'sd2147483647;
    lo_lim = -36'sd2147483648;
    if (v > hi_lim) begin
      return 32'sh7FFFFFFF;
    end else if (v < lo_lim) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    if (v > 21'sd32767) begin
      return 16'sh7FFF;
    end else if (v < -21'sd32768) begin
      return 16'sh8000;
    end
    return v[15:0];
  endfunction

endpackage

>>> hdl/svf_chan_if.sv
// valid/ready channel interfaces for the filter's sample input and result
// no dependencies
interface svf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] in_sample;
  logic        [15:0] cutoff_hz;

  modport source(output valid, output in_sample, output cutoff_hz, input ready);
  modport sink(input valid, input in_sample, input cutoff_hz, output ready);
endinterface

interface svf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] out_sample;

  modport source(output valid, output out_sample, input ready);
  modport sink(input valid, input out_sample, output ready);
endinterface

>>> hdl/state_variable_filter_2x.sv
// top level of the two-pass state-variable filter: config registers, datapath, output stage
// depends on svf_pkg, svf_chan_if, svf_mul and svf_seq
//
// Chamberlin state-variable filter run twice per sample. Each input transaction carries a
// Q1.15 sample and a cutoff in hertz; one filtered Q1.15 sample comes out per transaction.
// All products go through one shared 33x33 multiplier with a registered output; the cutoff and
// gain products followed by two passes (three dependent products and their updates each) on
// that multiplier set the time from acceptance to the result register. In bypass the sample
// skips the passes and goes from ST_DONE into the result register, and the integrators are
// left untouched. The next sample is accepted while a result is still waiting in the output
// register.
// Configuration is a plain write port (index 0 bypass, 1 mode, 2 damping, 3 input gain,
// 4 rate factor); write it only while no sample is in flight.
module state_variable_filter_2x (
  input  logic             clk,
  input  logic             rst_n,
  svf_in_if.sink           in_ch,
  svf_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [23:0]      cfg_wdata
);
  import svf_pkg::*;

  // configuration registers
  logic               bypass_on_r;
  logic [2:0]         filter_mode_r;
  logic signed [15:0] damping_coef_r;
  logic [14:0]        input_gain_r;
  logic [23:0]        rate_factor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bypass_on_r    <= 1'b0;
      filter_mode_r  <= 3'd0;
      damping_coef_r <= 16'sd0;
      input_gain_r   <= 15'd0;
      rate_factor_r  <= RATE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BYPASS: bypass_on_r    <= cfg_wdata[0];
        REG_MODE:   filter_mode_r  <= cfg_wdata[2:0];
        REG_DAMP:   damping_coef_r <= cfg_wdata[15:0];
        REG_GAIN:   input_gain_r   <= cfg_wdata[14:0];
        REG_RATE:   rate_factor_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // sequencer
  svf_ctrl_t ctrl;
  logic      in_fire;
  logic      out_busy;
  logic      in_ready;
  logic      out_valid_r;

  assign in_fire  = in_ch.valid && in_ready;
  assign out_busy = out_valid_r && !out_ch.ready;
  assign in_ch.ready = in_ready;

  svf_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .bypass   (bypass_on_r),
    .out_busy (out_busy),
    .in_ready (in_ready),
    .ctrl     (ctrl)
  );

  // working registers
  logic signed [15:0] x_r;
  logic        [15:0] cutoff_r;
  logic        [16:0] f_r;
  logic signed [31:0] gx_r;
  logic signed [31:0] low_r;
  logic signed [31:0] band_r;
  logic signed [31:0] high_r;
  logic signed [34:0] acc_r;

  // shared multiplier operands
  logic signed [32:0] op_a;
  logic signed [32:0] op_b;
  logic signed [65:0] prod;

  always_comb begin
    case (ctrl.mul_op)
      MUL_CR: begin
        op_a = {17'd0, cutoff_r};
        op_b = {9'd0, rate_factor_r};
      end
      MUL_GX: begin
        op_a = {18'd0, input_gain_r};
        op_b = 33'(x_r);
      end
      MUL_FB: begin
        op_a = {16'd0, f_r};
        op_b = 33'(band_r);
      end
      MUL_DB: begin
        op_a = 33'(damping_coef_r);
        op_b = 33'(band_r);
      end
      MUL_FH: begin
        op_a = {16'd0, f_r};
        op_b = 33'(high_r);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  svf_mul u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  // datapath next values; products shifted with floor via arithmetic slices
  logic        [16:0] f_nxt;
  logic signed [31:0] gx_nxt;
  logic signed [35:0] low_sum;
  logic signed [35:0] high_sum;
  logic signed [35:0] band_sum;
  logic signed [33:0] sel;
  logic signed [34:0] acc_nxt;

  assign f_nxt   = (|prod[39:33]) ? F_MAX : prod[32:16];
  assign gx_nxt  = prod[32:1];
  assign low_sum = 36'(low_r) + 36'($signed(prod[49:16]));
  assign high_sum = 36'(gx_r) - 36'(low_r) - prod[49:14];
  assign band_sum = 36'(band_r) + 36'($signed(prod[49:16]));

  always_comb begin
    case (filter_mode_r)
      MODE_LOW:   sel = 34'(low_r);
      MODE_HIGH:  sel = 34'(high_r);
      MODE_BAND:  sel = 34'(band_r);
      MODE_NOTCH: sel = 34'(high_r) + 34'(low_r);
      MODE_LMH:   sel = 34'(low_r) - 34'(high_r);
      default:    sel = '0;
    endcase
  end

  assign acc_nxt = acc_r + 35'(sel);

  always_ff @(posedge clk) begin
    if (in_fire) begin
      x_r      <= in_ch.in_sample;
      cutoff_r <= in_ch.cutoff_hz;
    end
    if (ctrl.upd_f) begin
      f_r <= f_nxt;
    end
    if (ctrl.upd_gx) begin
      gx_r <= gx_nxt;
    end
    if (ctrl.upd_high) begin
      high_r <= sat32(high_sum);
    end
  end

  // integrators and accumulator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= 32'sd0;
      band_r <= 32'sd0;
      acc_r  <= 35'sd0;
    end else begin
      if (ctrl.upd_low) begin
        low_r <= sat32(low_sum);
      end
      if (ctrl.upd_band) begin
        band_r <= sat32(band_sum);
      end
      if (ctrl.clr_acc) begin
        acc_r <= 35'sd0;
      end else if (ctrl.upd_acc) begin
        acc_r <= acc_nxt;
      end
    end
  end

  // output register
  logic signed [15:0] out_sample_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      // half the two-pass sum, Q.28 down to Q.15
      out_sample_r <= bypass_on_r ? x_r : sat16(acc_r[34:14]);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.out_sample = out_sample_r;

endmodule

>>> hdl/svf_mul.sv
// shared signed multiplier with registered product
// depends on nothing; used by state_variable_filter_2x
module svf_mul (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod
);

  logic signed [65:0] prod_r;
  logic signed [65:0] prod_nxt;

  assign prod_nxt = op_a * op_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
  end

  assign prod = prod_r;

endmodule

>>> hdl/svf_seq.sv
// sequencer stepping one sample through two filter passes on the shared multiplier (no passes in bypass)
// depends on svf_pkg
module svf_seq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_fire,
  input  logic              bypass,
  input  logic              out_busy,
  output logic              in_ready,
  output svf_pkg::svf_ctrl_t ctrl
);
  import svf_pkg::*;

  svf_state_t state_r, state_nxt;
  logic       pass_r, pass_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pass_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pass_r  <= pass_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    pass_nxt  = pass_r;
    in_ready  = 1'b0;
    ctrl      = '0;
    ctrl.mul_op = MUL_CR;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          ctrl.clr_acc = 1'b1;
          pass_nxt     = 1'b0;
          state_nxt    = bypass ? ST_DONE : ST_F;
        end
      end
      ST_F: begin
        ctrl.mul_op = MUL_CR;
        state_nxt   = ST_G;
      end
      ST_G: begin
        ctrl.mul_op = MUL_GX;
        ctrl.upd_f  = 1'b1;
        state_nxt   = ST_LB;
      end
      ST_LB: begin
        // first pass picks up the gain product issued in ST_G
        ctrl.mul_op = MUL_FB;
        ctrl.upd_gx = !pass_r;
        state_nxt   = ST_DB;
      end
      ST_DB: begin
        ctrl.mul_op  = MUL_DB;
        ctrl.upd_low = 1'b1;
        state_nxt    = ST_HI;
      end
      ST_HI: begin
        ctrl.upd_high = 1'b1;
        state_nxt     = ST_FH;
      end
      ST_FH: begin
        ctrl.mul_op = MUL_FH;
        state_nxt   = ST_BD;
      end
      ST_BD: begin
        ctrl.upd_band = 1'b1;
        state_nxt     = ST_ACC;
      end
      ST_ACC: begin
        ctrl.upd_acc = 1'b1;
        if (pass_r) begin
          state_nxt = ST_DONE;
        end else begin
          pass_nxt  = 1'b1;
          state_nxt = ST_LB;
        end
      end
      ST_DONE: begin
        if (!out_busy) begin
          ctrl.finish = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
